// File: src/pud_pkg.sv
package pud_pkg;

  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_PCT   = 8'h25;
  localparam logic [7:0] CH_U     = 8'h75;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [5:0] BAD_NIBBLE = 6'h3F;
  localparam logic [7:0] BAD_BYTE   = 8'hFF;

  localparam logic REG_WIDE_ENABLE = 1'b0;
  localparam logic REG_SWAP_ORDER  = 1'b1;

  typedef enum logic [2:0] {
    PH_IDLE = 3'd0,
    PH_PCT  = 3'd1,
    PH_N1   = 3'd2,
    PH_U    = 3'd3,
    PH_W1   = 3'd4,
    PH_W2   = 3'd5,
    PH_W3   = 3'd6
  } pud_phase_t;

  // Up to two decoded bytes produced by one input character.
  typedef struct packed {
    logic [1:0] n;
    logic [7:0] b0;
    logic       l0;
    logic [7:0] b1;
    logic       l1;
  } pud_pair_t;

  function automatic logic [5:0] nib(input logic [7:0] c);
    logic [5:0] v;
    v = BAD_NIBBLE;
    if (c >= 8'h30 && c <= 8'h39) v = 6'(c - 8'h30);
    else if (c >= 8'h41 && c <= 8'h46) v = 6'(c - 8'h41 + 8'd10);
    else if (c >= 8'h61 && c <= 8'h66) v = 6'(c - 8'h61 + 8'd10);
    return v;
  endfunction

  // High nibble keeps its low four bits; an invalid low nibble spills into bits 5:4.
  function automatic logic [7:0] join_nib(input logic [5:0] hi, input logic [5:0] lo);
    return {hi[3:0], 4'b0000} | {2'b00, lo};
  endfunction

endpackage

// File: src/pud_ifs.sv
interface pud_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_char;
  logic       in_last;
  modport source (output valid, output in_char, output in_last, input ready);
  modport sink (input valid, input in_char, input in_last, output ready);
endinterface

interface pud_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       out_last;
  modport source (output valid, output out_byte, output out_last, input ready);
  modport sink (input valid, input out_byte, input out_last, output ready);
endinterface

interface pud_cfg_if;
  logic valid;
  logic ready;
  logic index;
  logic data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// File: src/pud_decode.sv
module pud_decode
  import pud_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       accept,
  input  logic [7:0] in_char,
  input  logic       in_last,
  input  logic       wide_en,
  input  logic       swap,
  output pud_pair_t  pair
);

  pud_phase_t phase, phase_next;
  logic [5:0] acc, acc_next;
  logic [7:0] held, held_next;

  function automatic logic [15:0] order(input logic sw, input logic [7:0] first,
                                        input logic [7:0] second);
    return sw ? {second, first} : {first, second};
  endfunction

  always_comb begin
    logic [5:0]  nv;
    logic [15:0] pr;
    nv = nib(in_char);
    pr = '0;
    phase_next = phase;
    acc_next   = acc;
    held_next  = held;
    pair       = '0;

    unique case (phase)
      PH_PCT: begin
        if (wide_en && in_char == CH_U) begin
          phase_next = PH_U;
        end else begin
          acc_next   = nv;
          phase_next = PH_N1;
        end
      end
      PH_N1: begin
        pair.n     = 2'd1;
        pair.b0    = join_nib(acc, nv);
        phase_next = PH_IDLE;
      end
      PH_U: begin
        acc_next   = nv;
        phase_next = PH_W1;
      end
      PH_W1: begin
        held_next  = join_nib(acc, nv);
        phase_next = PH_W2;
      end
      PH_W2: begin
        acc_next   = nv;
        phase_next = PH_W3;
      end
      PH_W3: begin
        pr         = order(swap, held, join_nib(acc, nv));
        pair.n     = 2'd2;
        pair.b0    = pr[15:8];
        pair.b1    = pr[7:0];
        phase_next = PH_IDLE;
      end
      default: begin
        phase_next = PH_IDLE;
        if (in_char == CH_PLUS) begin
          pair.n  = 2'd1;
          pair.b0 = CH_SPACE;
        end else if (in_char == CH_PCT) begin
          phase_next = PH_PCT;
        end else begin
          pair.n  = 2'd1;
          pair.b0 = in_char;
        end
      end
    endcase

    if (in_last) begin
      // Close an open escape: missing digits read as invalid.
      unique case (phase_next)
        PH_PCT: begin
          pair.n  = 2'd1;
          pair.b0 = BAD_BYTE;
        end
        PH_N1: begin
          pair.n  = 2'd1;
          pair.b0 = join_nib(acc_next, BAD_NIBBLE);
        end
        PH_U:  pr = order(swap, BAD_BYTE, BAD_BYTE);
        PH_W1: pr = order(swap, join_nib(acc_next, BAD_NIBBLE), BAD_BYTE);
        PH_W2: pr = order(swap, held_next, BAD_BYTE);
        PH_W3: pr = order(swap, held_next, join_nib(acc_next, BAD_NIBBLE));
        default: ;
      endcase
      if (phase_next == PH_U || phase_next == PH_W1 || phase_next == PH_W2 ||
          phase_next == PH_W3) begin
        pair.n  = 2'd2;
        pair.b0 = pr[15:8];
        pair.b1 = pr[7:0];
      end
      pair.l0    = (pair.n == 2'd1);
      pair.l1    = (pair.n == 2'd2);
      phase_next = PH_IDLE;
      acc_next   = '0;
      held_next  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_IDLE;
      acc   <= '0;
      held  <= '0;
    end else if (accept) begin
      phase <= phase_next;
      acc   <= acc_next;
      held  <= held_next;
    end
  end

endmodule

// File: src/pud_outbuf.sv
module pud_outbuf
  import pud_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      load,
  input  pud_pair_t pair,
  output logic      room,
  pud_out_if.source out_ch
);

  logic [1:0] cnt, cnt_next;
  logic [7:0] byte0, byte1;
  logic       last0, last1;
  logic       pop;

  assign out_ch.valid    = (cnt != 2'd0);
  assign out_ch.out_byte = byte0;
  assign out_ch.out_last = last0;
  assign pop  = out_ch.valid && out_ch.ready;
  // Take a new pair only when the buffer is empty by the end of this cycle.
  assign room = (cnt == 2'd0) || (cnt == 2'd1 && out_ch.ready);

  always_comb begin
    cnt_next = cnt;
    if (load)     cnt_next = pair.n;
    else if (pop) cnt_next = cnt - 2'd1;
  end

  always_ff @(posedge clk) begin
    if (rst) cnt <= '0;
    else     cnt <= cnt_next;
  end

  always_ff @(posedge clk) begin
    if (load) begin
      byte0 <= pair.b0;
      last0 <= pair.l0;
      byte1 <= pair.b1;
      last1 <= pair.l1;
    end else if (pop) begin
      byte0 <= byte1;
      last0 <= last1;
    end
  end

endmodule

// File: src/percent_unescape_decoder.sv
// URL percent-unescape decoder, one character per transaction.
//
// in_ch  (sink):   in_char / in_last, one escaped character per transaction.
// out_ch (source): out_byte / out_last, one decoded byte per transaction;
//                  out_last marks the final byte of a string.
// cfg    (sink):   index 0 = wide_escape_enable, index 1 = swap_wide_order.
//                  Always ready; write only while the decoder is idle.
//
// Timing: a result appears on out_ch in the cycle after the character that
// completes it is accepted. Throughput: one character per cycle while out_ch
// is ready and each character yields at most one byte; a character that
// yields two bytes (wide escape end, or a string ending inside a wide
// escape) holds in_ch ready low while the second byte drains through the
// two-entry result buffer.
// Reset: escape phase returns to idle, both config bits read 1, the result
// buffer empties.
// Stall: when out_ch is not ready, results stay in the buffer and in_ch
// ready drops once no room remains for the next character's results.
module percent_unescape_decoder
  import pud_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  pud_in_if.sink    in_ch,
  pud_out_if.source out_ch,
  pud_cfg_if.sink   cfg
);

  logic      wide_en;
  logic      swap;
  logic      room;
  logic      accept;
  pud_pair_t pair;

  // Config writes land immediately.
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      wide_en <= 1'b1;
      swap    <= 1'b1;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        REG_WIDE_ENABLE: wide_en <= cfg.data;
        REG_SWAP_ORDER:  swap    <= cfg.data;
        default: ;
      endcase
    end
  end

  // Accept a character whenever the buffer can take its results.
  assign in_ch.ready = room;
  assign accept      = in_ch.valid && room;

  pud_decode u_decode (
    .clk     (clk),
    .rst     (rst),
    .accept  (accept),
    .in_char (in_ch.in_char),
    .in_last (in_ch.in_last),
    .wide_en (wide_en),
    .swap    (swap),
    .pair    (pair)
  );

  pud_outbuf u_outbuf (
    .clk    (clk),
    .rst    (rst),
    .load   (accept),
    .pair   (pair),
    .room   (room),
    .out_ch (out_ch)
  );

endmodule

// File: tb/tb.sv
module tb;
  import pud_pkg::*;

  // Abort the run if it goes far beyond the slowest legal run.
  localparam int CYCLE_LIMIT = 500000;
  localparam int MAX_REPORTS = 30;

  typedef struct {
    logic [7:0] value;
    logic       is_end;
  } decoded_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  pud_in_if  in_ch ();
  pud_out_if out_ch ();
  pud_cfg_if cfg_ch ();

  percent_unescape_decoder DUT (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg    (cfg_ch)
  );

  always #5 clk = ~clk;

  // Decoder model state, kept alongside the block and advanced on every
  // accepted transaction.
  logic       wide_en;
  logic       swap_order;
  pud_phase_t dec_phase;
  logic [7:0] first_nib;
  logic [7:0] held_wide;

  // Decoded bytes still owed by the block, oldest first.
  decoded_t   owed_bytes[$];

  int cycle_count;
  int chars_sent;
  int bytes_checked;
  int mismatches;
  int strings_sent;

  // Traffic shaping: percent chance per cycle of a sender gap or a receiver
  // stall, plus a flag that holds the receiver off for a long stretch.
  int   send_gap_pct;
  int   recv_stall_pct;
  logic rx_hold;

  string hex_chars = "0123456789abcdefABCDEF";

  // Hex digit value of one character; anything else maps to the bad nibble.
  function automatic logic [7:0] hex_value(input logic [7:0] c);
    if (c >= "0" && c <= "9") return c - "0";
    if (c >= "A" && c <= "F") return c - "A" + 8'd10;
    if (c >= "a" && c <= "f") return c - "a" + 8'd10;
    return {2'b00, BAD_NIBBLE};
  endfunction

  // Combine two nibbles; an invalid low nibble spills into the high half.
  function automatic logic [7:0] pack_byte(input logic [7:0] hi, input logic [7:0] lo);
    logic [7:0] shifted;
    shifted = hi << 4;
    return shifted | lo;
  endfunction

  // Advance the decoder model by one character and queue the bytes it owes.
  task automatic predict_decode(input logic [7:0] c, input logic is_end);
    logic [7:0] outs[$];
    logic [7:0] bad;
    logic [7:0] wide_a;
    logic [7:0] wide_b;
    logic       have_pair;
    decoded_t   d;
    bad       = {2'b00, BAD_NIBBLE};
    have_pair = 1'b0;
    wide_a    = '0;
    wide_b    = '0;
    case (dec_phase)
      PH_PCT: begin
        // Wide mode is decided on the character right after the percent sign.
        if (wide_en && c == CH_U) begin
          dec_phase = PH_U;
        end else begin
          first_nib = hex_value(c);
          dec_phase = PH_N1;
        end
      end
      PH_N1: begin
        outs.push_back(pack_byte(first_nib, hex_value(c)));
        dec_phase = PH_IDLE;
      end
      PH_U: begin
        first_nib = hex_value(c);
        dec_phase = PH_W1;
      end
      PH_W1: begin
        held_wide = pack_byte(first_nib, hex_value(c));
        dec_phase = PH_W2;
      end
      PH_W2: begin
        first_nib = hex_value(c);
        dec_phase = PH_W3;
      end
      PH_W3: begin
        wide_a    = held_wide;
        wide_b    = pack_byte(first_nib, hex_value(c));
        have_pair = 1'b1;
        dec_phase = PH_IDLE;
      end
      default: begin
        dec_phase = PH_IDLE;
        if (c == CH_PLUS) outs.push_back(CH_SPACE);
        else if (c == CH_PCT) dec_phase = PH_PCT;
        else outs.push_back(c);
      end
    endcase
    // String ends inside an escape: pad the missing digits with bad nibbles.
    if (is_end) begin
      case (dec_phase)
        PH_PCT: outs.push_back(pack_byte(bad, bad));
        PH_N1:  outs.push_back(pack_byte(first_nib, bad));
        PH_U: begin
          wide_a = pack_byte(bad, bad);
          wide_b = pack_byte(bad, bad);
          have_pair = 1'b1;
        end
        PH_W1: begin
          wide_a = pack_byte(first_nib, bad);
          wide_b = pack_byte(bad, bad);
          have_pair = 1'b1;
        end
        PH_W2: begin
          wide_a = held_wide;
          wide_b = pack_byte(bad, bad);
          have_pair = 1'b1;
        end
        PH_W3: begin
          wide_a = held_wide;
          wide_b = pack_byte(first_nib, bad);
          have_pair = 1'b1;
        end
        default: ;
      endcase
      dec_phase = PH_IDLE;
      first_nib = '0;
      held_wide = '0;
    end
    // Byte order of a wide escape is taken from the register at completion.
    if (have_pair) begin
      if (swap_order) begin
        outs.push_back(wide_b);
        outs.push_back(wide_a);
      end else begin
        outs.push_back(wide_a);
        outs.push_back(wide_b);
      end
    end
    foreach (outs[i]) begin
      d.value  = outs[i];
      d.is_end = is_end && (i == outs.size() - 1);
      owed_bytes.push_back(d);
    end
  endtask

  // Single sampling point: register writes, input transactions and output
  // transactions are all observed here at the rising edge, in that order.
  always @(posedge clk) begin
    decoded_t want;
    if (!rst) begin
      if (cfg_ch.valid && cfg_ch.ready) begin
        if (cfg_ch.index == REG_WIDE_ENABLE) wide_en = cfg_ch.data;
        else swap_order = cfg_ch.data;
      end
      if (in_ch.valid && in_ch.ready) begin
        predict_decode(in_ch.in_char, in_ch.in_last);
        chars_sent++;
      end
      if (out_ch.valid && out_ch.ready) begin
        if (owed_bytes.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("%0t: unexpected output byte %02h last %0b (nothing owed)",
                     $time, out_ch.out_byte, out_ch.out_last);
        end else begin
          want = owed_bytes.pop_front();
          bytes_checked++;
          if (out_ch.out_byte !== want.value || out_ch.out_last !== want.is_end) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
              $display("%0t: mismatch out_byte exp %02h act %02h, out_last exp %0b act %0b",
                       $time, want.value, out_ch.out_byte, want.is_end, out_ch.out_last);
          end
        end
      end
    end
  end

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles, %0d bytes still owed",
               $time, cycle_count, owed_bytes.size());
      $display("FAILED: results differ");
      $finish;
    end
  end

  // Receiver: drive ready at the falling edge. Stall at random, or hold off
  // entirely while a back-pressure stretch is in progress.
  always @(negedge clk) begin
    if (rx_hold) out_ch.ready <= 1'b0;
    else out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Hold the receiver off for a counted number of cycles.
  task automatic hold_receiver(input int cycles);
    rx_hold = 1'b1;
    repeat (cycles) @(posedge clk);
    rx_hold = 1'b0;
  endtask

  // Send one character as one transaction. Call at a falling edge; return
  // at the falling edge after acceptance with valid still high, so a
  // back-to-back character keeps valid asserted without a glitch.
  task automatic send_char(input logic [7:0] c, input logic is_end);
    while ($urandom_range(99) < send_gap_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.in_char <= c;
    in_ch.in_last <= is_end;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
  endtask

  task automatic send_string(input string s);
    for (int i = 0; i < s.len(); i++) send_char(s[i], i == s.len() - 1);
    strings_sent++;
  endtask

  // Drop valid and wait until every owed byte has come out, then let
  // characters that produce nothing settle.
  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    while (owed_bytes.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // Write both registers back to back. Call only while the decoder is idle.
  task automatic configure(input logic wide, input logic swap);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= REG_WIDE_ENABLE;
    cfg_ch.data  <= wide;
    do @(posedge clk); while (!cfg_ch.ready);
    @(negedge clk);
    cfg_ch.index <= REG_SWAP_ORDER;
    cfg_ch.data  <= swap;
    do @(posedge clk); while (!cfg_ch.ready);
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
    @(negedge clk);
  endtask

  function automatic logic [7:0] pick_digit();
    if ($urandom_range(99) < 85) return hex_chars[$urandom_range(hex_chars.len() - 1)];
    return 8'($urandom_range(255));
  endfunction

  // Build strings mostly out of well-formed escapes with random digits, with
  // noise characters, stray digits and strings cut off inside an escape.
  task automatic send_random_strings(input int n_chars);
    logic [7:0] text[$];
    int         len;
    int         pick;
    int         sent;
    sent = 0;
    while (sent < n_chars) begin
      text.delete();
      len = ($urandom_range(9) == 0) ? $urandom_range(1, 3) : $urandom_range(2, 16);
      while (text.size() < len) begin
        pick = $urandom_range(99);
        if (pick < 40) begin
          text.push_back(8'($urandom_range(255)));
        end else if (pick < 50) begin
          text.push_back(CH_PLUS);
        end else if (pick < 72) begin
          text.push_back(CH_PCT);
          text.push_back(pick_digit());
          text.push_back(pick_digit());
        end else begin
          text.push_back(CH_PCT);
          text.push_back(CH_U);
          repeat (4) text.push_back(pick_digit());
        end
      end
      text = text[0:len-1];
      foreach (text[i]) send_char(text[i], i == len - 1);
      sent += len;
      strings_sent++;
    end
  endtask

  // Directed cases at reset settings: plain characters, plus, narrow and
  // wide escapes, extreme byte values, escape characters in digit positions
  // and strings that end inside each escape phase.
  task automatic test_directed();
    send_gap_pct   = 0;
    recv_stall_pct = 0;
    send_string("a+B");
    send_string("%4A");
    send_string("%u00e9");
    send_char(8'h00, 1'b0);
    send_char(8'hFF, 1'b1);
    strings_sent++;
    send_string("%%+");
    send_string("%");
    send_string("%9");
    send_string("%u");
    send_string("%u1");
    send_string("%u1f");
    send_string("%u1f7");
    wait_idle();
  endtask

  // Wide escapes with the natural byte order, complete and cut short.
  task automatic test_wide_order();
    configure(1'b1, 1'b0);
    send_string("%uABcd");
    send_string("%uAB");
    send_string("%u0");
    wait_idle();
  endtask

  // Wide mode off: the u after the percent sign is just an invalid digit.
  task automatic test_narrow_mode();
    configure(1'b0, 1'b1);
    send_string("%u7");
    send_string("%u");
    send_string("%U5");
    wait_idle();
  endtask

  // Hold the receiver off while the sender keeps offering characters, so
  // the result buffer fills and the decoder stalls its input.
  task automatic test_backpressure();
    configure(1'b1, 1'b1);
    send_gap_pct   = 0;
    recv_stall_pct = 0;
    fork
      hold_receiver(300);
      send_random_strings(80);
    join
    wait_idle();
  endtask

  task automatic test_random_traffic(input int gap_pct, input int stall_pct,
                                     input logic wide, input logic swap,
                                     input int n_chars);
    configure(wide, swap);
    send_gap_pct   = gap_pct;
    recv_stall_pct = stall_pct;
    send_random_strings(n_chars);
    wait_idle();
  endtask

  initial begin
    // Drive every input to a known value before the first edge.
    in_ch.valid    = 1'b0;
    in_ch.in_char  = '0;
    in_ch.in_last  = 1'b0;
    out_ch.ready   = 1'b0;
    cfg_ch.valid   = 1'b0;
    cfg_ch.index   = REG_WIDE_ENABLE;
    cfg_ch.data    = 1'b0;
    rx_hold        = 1'b0;
    send_gap_pct   = 0;
    recv_stall_pct = 0;
    cycle_count    = 0;
    chars_sent     = 0;
    bytes_checked  = 0;
    mismatches     = 0;
    strings_sent   = 0;
    // Model starts from the reset values of the block.
    wide_en    = 1'b1;
    swap_order = 1'b1;
    dec_phase  = PH_IDLE;
    first_nib  = '0;
    held_wide  = '0;

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_directed();
    test_wide_order();
    test_narrow_mode();
    test_backpressure();
    // Random phases: no gaps, sender gaps, receiver stalls, both.
    test_random_traffic(0, 0, 1'b1, 1'b1, 325);
    test_random_traffic(88, 0, 1'b1, 1'b0, 325);
    test_random_traffic(0, 88, 1'b0, 1'b1, 325);
    test_random_traffic(25, 25, 1'b0, 1'b0, 325);
    test_random_traffic(25, 25, 1'b1, 1'b1, 100);

    repeat (10) @(negedge clk);
    $display("Decoded %0d strings: %0d characters in, %0d bytes checked, %0d mismatches.",
             strings_sent, chars_sent, bytes_checked, mismatches);
    $display("Covered both wide modes, both byte orders, cut-off escapes and a long stall.");
    if (mismatches == 0 && owed_bytes.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
